### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation codes and status codes used by the queue top level.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Queue geometry.
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = ADDR_W + 1;

	// Fixed widths of the item fields.
	localparam int MODE_W = 2;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 7;

	// Operation requested by an input beat.
	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	// Status returned with each result beat.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

### design/double_ended_queue.sv
// Double-ended queue: an accepted input beat gets its result beat in the cycle after it.
// Throughput is one beat per cycle unless in_stall holds the input; the ring store is
// written and read at the accept edge, so pointer updates never wait on memory data.
// in_stall is raised only while a result beat is held against out_stall.
// Reset clears the head pointer, the entry count and the result valid at once.
// The ring store is not cleared; pops only read entries that a push has written.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded deque of signed values in a ring store, with front and rear push/pop.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [VAL_W-1:0]  push_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  popped_value,
	output logic [STAT_W-1:0] status,
	output logic [OCC_W-1:0]  occupancy
);

	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	logic              valid_s1;
	logic              pop_ok_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  occ_s1;

	logic              accept;
	op_t               op;
	logic              is_push;
	logic              full;
	logic              empty;
	logic [SUM_W-1:0]  sum_rear;
	logic [SUM_W-1:0]  sum_last;
	logic [ADDR_W-1:0] head_dec;
	logic [ADDR_W-1:0] head_inc;
	logic [ADDR_W-1:0] rear_wr;
	logic [ADDR_W-1:0] rear_rd;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	status_t           status_d;
	logic              pop_ok_d;

	// Handshake: hold the input while a result beat is stalled.
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	assign op      = op_t'(mode);
	assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	// Ring index arithmetic, each index wrapped with one compare; the rear ones also subtract.
	assign head_dec = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign sum_rear = SUM_W'(head_q) + SUM_W'(count_q);
	assign sum_last = sum_rear - 1'b1;
	assign rear_wr  = (sum_rear >= SUM_W'(DEPTH)) ? ADDR_W'(sum_rear - SUM_W'(DEPTH))
	                                              : ADDR_W'(sum_rear);
	assign rear_rd  = (sum_last >= SUM_W'(DEPTH)) ? ADDR_W'(sum_last - SUM_W'(DEPTH))
	                                              : ADDR_W'(sum_last);

	// Operation decode: next pointers and the memory access of this beat.
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = ST_DONE;
		pop_ok_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = rear_wr;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		if (is_push && full) begin
			status_d = ST_FULL;
		end else if (!is_push && empty) begin
			status_d = ST_EMPTY;
		end else begin
			unique case (op)
				OP_PUSH_FRONT: begin
					head_d  = head_dec;
					count_d = count_q + 1'b1;
					wr_en   = accept;
					wr_addr = head_dec;
				end
				OP_PUSH_REAR: begin
					count_d = count_q + 1'b1;
					wr_en   = accept;
					wr_addr = rear_wr;
				end
				OP_POP_FRONT: begin
					head_d   = head_inc;
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
					rd_en    = accept;
					rd_addr  = head_q;
				end
				OP_POP_REAR: begin
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
					rd_en    = accept;
					rd_addr  = rear_rd;
				end
				default: begin
					head_d = head_q;
				end
			endcase
		end
	end

	dq_ring_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_value[DATA_WIDTH-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result payload, aligned with the memory read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= pop_ok_d;
			status_s1 <= status_d;
			occ_s1    <= count_d;
		end
	end

	// Output beat.
	assign out_valid    = valid_s1;
	assign status       = status_s1;
	assign occupancy    = OCC_W'(occ_s1);
	assign popped_value = pop_ok_s1 ? VAL_W'(rd_data)
	                    : ((status_s1 == ST_EMPTY) ? '1 : '0);

`ifndef SYNTHESIS
	// The count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	// A dropped push reports a full queue.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 == ST_FULL) |-> (occ_s1 == CNT_W'(DEPTH)))
		else $error("full status without full occupancy");

	// A pop on an empty queue returns minus one and zero occupancy.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 == ST_EMPTY) |-> (popped_value == '1 && occ_s1 == '0))
		else $error("empty pop result malformed");

	// A successful push grows the count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow count");

	// The input is held only while a result beat waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_stall))
		else $error("input stalled without a waiting result");
`endif

endmodule

### design/dq_ring_ram.sv
// ----------------------------------------------------------------------------
// Ring store memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dq_ring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
